>>> hw/rtl/matrix_chain_order_dp_assert.svh
// Assertion macros used by the matrix chain order RTL.
`ifndef MATRIX_CHAIN_ORDER_DP_ASSERT_SVH
`define MATRIX_CHAIN_ORDER_DP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define MCOD_ASSERT_ALW(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MCOD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCOD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/mcod_pkg.sv
// Package with widths, types and constants of the matrix chain order block.
`timescale 1ns / 1ps
`default_nettype none
package mcod_pkg;

   localparam int MAX_MATRICES_DEF = 16;

   localparam int DIM_W   = 12;
   localparam int COST_W  = 40;
   localparam int SPLIT_W = 4;
   localparam int TOTAL_W = 5;
   localparam int PROD1_W = 2 * DIM_W;
   localparam int PROD_W  = 3 * DIM_W;

   localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_ISSUE,
      ST_DRAIN,
      ST_FETCH,
      ST_DONE
   } state_type;

   // Sequencer strobes toward the evaluation pipeline.
   typedef struct packed {
      logic setup;
      logic issue;
      logic last;
      logic a_zero;
   } ctl_type;

   typedef struct packed {
      logic rd_a;
      logic rd_b;
      logic wr;
   } dim_cmd_type;

   typedef struct packed {
      logic rd_a;
      logic rd_b;
      logic rd_s;
      logic wr;
   } tbl_cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/mcod_chan_if.sv
// Valid/ready channel interfaces for dimension and result transactions.
`timescale 1ns / 1ps
`default_nettype none
interface mcod_req_if;
   logic                       valid;
   logic                       ready;
   logic [mcod_pkg::DIM_W-1:0] dim;
   logic                       last;

   modport source (output valid, output dim, output last, input ready);
   modport sink (input valid, input dim, input last, output ready);
endinterface

interface mcod_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mcod_pkg::COST_W-1:0]  min_cost;
   logic [mcod_pkg::SPLIT_W-1:0] top_split;
   logic [mcod_pkg::TOTAL_W-1:0] matrix_total;
   logic                         error;

   modport source (output valid, output min_cost, output top_split, output matrix_total,
                   output error, input ready);
   modport sink (input valid, input min_cost, input top_split, input matrix_total,
                 input error, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mcod_dim_mem.sv
// Dimension store: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module mcod_dim_mem #(
   parameter int  MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF,
   localparam int SLOTS = MAX_MATRICES + 1,
   localparam int DAW = $clog2(SLOTS)
) (
   input  logic                       clock,
   input  mcod_pkg::dim_cmd_type      cmd,
   input  logic [DAW-1:0]             wr_addr,
   input  logic [mcod_pkg::DIM_W-1:0] wr_data,
   input  logic [DAW-1:0]             rd_a_addr,
   input  logic [DAW-1:0]             rd_b_addr,
   output logic [mcod_pkg::DIM_W-1:0] rd_a_data,
   output logic [mcod_pkg::DIM_W-1:0] rd_b_data
);

   logic [mcod_pkg::DIM_W-1:0] store_ff [SLOTS];
   logic [mcod_pkg::DIM_W-1:0] rd_a_ff;
   logic [mcod_pkg::DIM_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_a) begin
         rd_a_ff <= store_ff[rd_a_addr];
      end
      if (cmd.rd_b) begin
         rd_b_ff <= store_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mcod_table_mem.sv
// Cost and split tables, addressed by interval {i, j}, with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module mcod_table_mem #(
   parameter int  MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF,
   localparam int IDX_W = $clog2(MAX_MATRICES),
   localparam int TAW = 2 * IDX_W,
   localparam int DEPTH = 1 << TAW
) (
   input  logic                        clock,
   input  mcod_pkg::tbl_cmd_type       cmd,
   input  logic [TAW-1:0]              a_addr,
   input  logic [TAW-1:0]              b_addr,
   input  logic [TAW-1:0]              wr_addr,
   input  logic [mcod_pkg::COST_W-1:0] wr_cost,
   input  logic [IDX_W-1:0]            wr_split,
   output logic [mcod_pkg::COST_W-1:0] cost_a,
   output logic [mcod_pkg::COST_W-1:0] cost_b,
   output logic [IDX_W-1:0]            split_a
);

   logic [mcod_pkg::COST_W-1:0] cost_ff [DEPTH];
   logic [IDX_W-1:0]            split_ff [DEPTH];
   logic [mcod_pkg::COST_W-1:0] cost_a_ff;
   logic [mcod_pkg::COST_W-1:0] cost_b_ff;
   logic [IDX_W-1:0]            split_a_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         cost_ff[wr_addr]  <= wr_cost;
         split_ff[wr_addr] <= wr_split;
      end
      if (cmd.rd_a) begin
         cost_a_ff <= cost_ff[a_addr];
      end
      if (cmd.rd_b) begin
         cost_b_ff <= cost_ff[b_addr];
      end
      if (cmd.rd_s) begin
         split_a_ff <= split_ff[a_addr];
      end
   end

   assign cost_a  = cost_a_ff;
   assign cost_b  = cost_b_ff;
   assign split_a = split_a_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mcod_eval.sv
// Split evaluation pipeline: partial costs, dimension product, running minimum.
`timescale 1ns / 1ps
`default_nettype none
module mcod_eval #(
   parameter int  MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF,
   localparam int IDX_W = $clog2(MAX_MATRICES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mcod_pkg::ctl_type           ctl,
   input  logic [IDX_W-1:0]            k,
   input  logic [mcod_pkg::DIM_W-1:0]  dim_a,
   input  logic [mcod_pkg::DIM_W-1:0]  dim_b,
   input  logic [mcod_pkg::COST_W-1:0] cost_a,
   input  logic [mcod_pkg::COST_W-1:0] cost_b,
   output logic                        done,
   output logic [mcod_pkg::COST_W-1:0] best,
   output logic [IDX_W-1:0]            best_k
);

   localparam int CW = mcod_pkg::COST_W;

   logic                          setup_q_ff;
   logic [mcod_pkg::DIM_W-1:0]    pi_ff;
   logic [mcod_pkg::DIM_W-1:0]    pj_ff;

   logic                          s0_valid_ff;
   logic                          s0_last_ff;
   logic                          s0_az_ff;
   logic [IDX_W-1:0]              s0_k_ff;

   logic                          s1_valid_ff;
   logic                          s1_last_ff;
   logic [IDX_W-1:0]              s1_k_ff;
   logic [mcod_pkg::PROD1_W-1:0]  prod1_ff;
   logic [mcod_pkg::PROD1_W-1:0]  prod1_in;
   logic [CW-1:0]                 sab1_ff;
   logic [CW-1:0]                 sab1_in;

   logic                          s2_valid_ff;
   logic                          s2_last_ff;
   logic [IDX_W-1:0]              s2_k_ff;
   logic [mcod_pkg::PROD_W-1:0]   prod_ff;
   logic [mcod_pkg::PROD_W-1:0]   prod_in;
   logic [CW-1:0]                 sab2_ff;

   logic [CW-1:0]                 best_ff;
   logic [CW-1:0]                 best_in;
   logic [IDX_W-1:0]              best_k_ff;
   logic [IDX_W-1:0]              best_k_in;
   logic                          done_ff;

   logic [CW-1:0]                 ca;
   logic [CW-1:0]                 cb;
   logic [CW:0]                   sum_ab;
   logic [CW:0]                   sum_c;
   logic [CW-1:0]                 cand;

   // Stage 1 works on the registered memory data. A single matrix costs zero,
   // so the diagonal halves of the split are forced to zero here.
   always_comb begin
      ca       = s0_az_ff ? '0 : cost_a;
      cb       = s0_last_ff ? '0 : cost_b;
      sum_ab   = {1'b0, ca} + {1'b0, cb};
      sab1_in  = sum_ab[CW] ? mcod_pkg::COST_SAT : sum_ab[CW-1:0];
      prod1_in = mcod_pkg::PROD1_W'(pi_ff) * mcod_pkg::PROD1_W'(dim_a);
      prod_in  = mcod_pkg::PROD_W'(prod1_ff) * mcod_pkg::PROD_W'(pj_ff);
      sum_c    = {1'b0, sab2_ff} + (CW + 1)'(prod_ff);
      cand     = sum_c[CW] ? mcod_pkg::COST_SAT : sum_c[CW-1:0];
   end

   // Splits arrive in rising k, and a tie replaces the best, so the later k wins.
   always_comb begin
      best_in   = best_ff;
      best_k_in = best_k_ff;
      if (ctl.setup) begin
         best_in = mcod_pkg::COST_SAT;
      end else if (s2_valid_ff && (best_ff >= cand)) begin
         best_in   = cand;
         best_k_in = s2_k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_q_ff  <= 1'b0;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         setup_q_ff  <= ctl.setup;
         s0_valid_ff <= ctl.issue;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff && s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (setup_q_ff) begin
         pi_ff <= dim_a;
         pj_ff <= dim_b;
      end
      s0_last_ff <= ctl.last;
      s0_az_ff   <= ctl.a_zero;
      s0_k_ff    <= k;
      s1_last_ff <= s0_last_ff;
      s1_k_ff    <= s0_k_ff;
      prod1_ff   <= prod1_in;
      sab1_ff    <= sab1_in;
      s2_last_ff <= s1_last_ff;
      s2_k_ff    <= s1_k_ff;
      prod_ff    <= prod_in;
      sab2_ff    <= sab1_ff;
      best_ff    <= best_in;
      best_k_ff  <= best_k_in;
   end

   assign done   = done_ff;
   assign best   = best_ff;
   assign best_k = best_k_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mcod_ctrl.sv
// Sequencer: dimension loading, diagonal sweep of the tables, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_chain_order_dp_assert.svh"
module mcod_ctrl #(
   parameter int  MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF,
   localparam int IDX_W = $clog2(MAX_MATRICES),
   localparam int M_W = IDX_W + 1,
   localparam int SLOTS = MAX_MATRICES + 1,
   localparam int DAW = $clog2(SLOTS),
   localparam int CNT_W = $clog2(SLOTS + 1),
   localparam int TAW = 2 * IDX_W
) (
   input  logic                        clock,
   input  logic                        reset,
   mcod_req_if.sink                    req_if,
   mcod_rsp_if.source                  rsp_if,
   output mcod_pkg::dim_cmd_type       dim_cmd,
   output logic [DAW-1:0]              dim_wr_addr,
   output logic [DAW-1:0]              dim_rd_a_addr,
   output logic [DAW-1:0]              dim_rd_b_addr,
   output mcod_pkg::tbl_cmd_type       tbl_cmd,
   output logic [TAW-1:0]              tbl_a_addr,
   output logic [TAW-1:0]              tbl_b_addr,
   output logic [TAW-1:0]              tbl_wr_addr,
   output mcod_pkg::ctl_type           ctl,
   output logic [IDX_W-1:0]            eval_k,
   input  logic                        eval_done,
   input  logic [mcod_pkg::COST_W-1:0] tbl_cost_a,
   input  logic [IDX_W-1:0]            tbl_split
);

   mcod_pkg::state_type state_ff;
   mcod_pkg::state_type state_in;

   logic [CNT_W-1:0]             cnt_ff;
   logic [CNT_W-1:0]             cnt_in;
   logic                         ovf_ff;
   logic                         ovf_in;
   logic [M_W-1:0]               m_ff;
   logic [M_W-1:0]               m_in;
   logic                         err_ff;
   logic                         err_in;
   logic [IDX_W-1:0]             diag_ff;
   logic [IDX_W-1:0]             diag_in;
   logic [IDX_W-1:0]             i_ff;
   logic [IDX_W-1:0]             i_in;
   logic [IDX_W-1:0]             k_ff;
   logic [IDX_W-1:0]             k_in;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [mcod_pkg::COST_W-1:0]  rsp_cost_ff;
   logic [mcod_pkg::COST_W-1:0]  rsp_cost_in;
   logic [mcod_pkg::SPLIT_W-1:0] rsp_split_ff;
   logic [mcod_pkg::SPLIT_W-1:0] rsp_split_in;
   logic [mcod_pkg::TOTAL_W-1:0] rsp_total_ff;
   logic [mcod_pkg::TOTAL_W-1:0] rsp_total_in;
   logic                         rsp_err_ff;
   logic                         rsp_err_in;

   logic                         req_fire;
   logic                         full;
   logic                         bad;
   logic                         rsp_free;
   logic                         k_end;
   logic                         i_more;
   logic                         d_more;
   logic [CNT_W-1:0]             cnt_step;
   logic [M_W-1:0]               m_new;
   logic [M_W-1:0]               m_last;
   logic [IDX_W-1:0]             j;
   logic [IDX_W-1:0]             k1;

   assign req_fire = req_if.valid && req_if.ready;
   assign full     = (cnt_ff == CNT_W'(SLOTS));
   assign cnt_step = full ? cnt_ff : cnt_ff + CNT_W'(1);
   // A dimension that finds the store full marks the chain as bad.
   assign bad      = ovf_ff || full || (cnt_step < CNT_W'(2));
   assign m_new    = M_W'(cnt_step - CNT_W'(1));
   assign m_last   = m_ff - M_W'(1);
   assign j        = i_ff + diag_ff;
   assign k1       = k_ff + IDX_W'(1);
   assign k_end    = (k1 == j);
   assign i_more   = (M_W'(j) + M_W'(1)) < m_ff;
   assign d_more   = (M_W'(diag_ff) + M_W'(1)) < m_ff;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // Next state. The drain state waits for the pipeline so that an interval's
   // cost is written before any later interval can read it.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcod_pkg::ST_LOAD: begin
            if (req_fire && req_if.last) begin
               state_in = (bad || (m_new == M_W'(1))) ? mcod_pkg::ST_DONE
                                                      : mcod_pkg::ST_SETUP;
            end
         end
         mcod_pkg::ST_SETUP: begin
            state_in = mcod_pkg::ST_ISSUE;
         end
         mcod_pkg::ST_ISSUE: begin
            if (k_end) begin
               state_in = mcod_pkg::ST_DRAIN;
            end
         end
         mcod_pkg::ST_DRAIN: begin
            if (eval_done) begin
               state_in = (i_more || d_more) ? mcod_pkg::ST_SETUP : mcod_pkg::ST_FETCH;
            end
         end
         mcod_pkg::ST_FETCH: begin
            state_in = mcod_pkg::ST_DONE;
         end
         mcod_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = mcod_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mcod_pkg::ST_LOAD;
         end
      endcase
   end

   // Outputs of the state machine: handshake, memory commands and addresses.
   always_comb begin
      req_if.ready  = 1'b0;
      ctl           = '0;
      dim_cmd       = '0;
      tbl_cmd       = '0;
      dim_rd_a_addr = DAW'(k1);
      tbl_a_addr    = {i_ff, k_ff};
      unique case (state_ff)
         mcod_pkg::ST_LOAD: begin
            req_if.ready = 1'b1;
            dim_cmd.wr   = req_if.valid && !full;
         end
         mcod_pkg::ST_SETUP: begin
            dim_cmd.rd_a  = 1'b1;
            dim_cmd.rd_b  = 1'b1;
            dim_rd_a_addr = DAW'(i_ff);
            ctl.setup     = 1'b1;
         end
         mcod_pkg::ST_ISSUE: begin
            dim_cmd.rd_a = 1'b1;
            tbl_cmd.rd_a = 1'b1;
            tbl_cmd.rd_b = 1'b1;
            ctl.issue    = 1'b1;
            ctl.last     = k_end;
            ctl.a_zero   = (k_ff == i_ff);
         end
         mcod_pkg::ST_DRAIN: begin
            tbl_cmd.wr = eval_done;
         end
         mcod_pkg::ST_FETCH: begin
            tbl_cmd.rd_a = 1'b1;
            tbl_cmd.rd_s = 1'b1;
            tbl_a_addr   = {IDX_W'(0), m_last[IDX_W-1:0]};
         end
         mcod_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign dim_wr_addr   = cnt_ff[DAW-1:0];
   assign dim_rd_b_addr = DAW'(j) + DAW'(1);
   assign tbl_b_addr    = {k1, j};
   assign tbl_wr_addr   = {i_ff, j};
   assign eval_k        = k_ff;

   // Next values of the counters and of the result register.
   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      m_in         = m_ff;
      err_in       = err_ff;
      diag_in      = diag_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_cost_in  = rsp_cost_ff;
      rsp_split_in = rsp_split_ff;
      rsp_total_in = rsp_total_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         mcod_pkg::ST_LOAD: begin
            if (req_if.valid) begin
               cnt_in = cnt_step;
               ovf_in = ovf_ff || full;
               if (req_if.last) begin
                  cnt_in  = '0;
                  ovf_in  = 1'b0;
                  err_in  = bad;
                  m_in    = m_new;
                  diag_in = IDX_W'(1);
                  i_in    = '0;
               end
            end
         end
         mcod_pkg::ST_SETUP: begin
            k_in = i_ff;
         end
         mcod_pkg::ST_ISSUE: begin
            k_in = k1;
         end
         mcod_pkg::ST_DRAIN: begin
            if (eval_done) begin
               if (i_more) begin
                  i_in = i_ff + IDX_W'(1);
               end else if (d_more) begin
                  diag_in = diag_ff + IDX_W'(1);
                  i_in    = '0;
               end
            end
         end
         mcod_pkg::ST_FETCH: begin
         end
         mcod_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_cost_in  = '0;
                  rsp_split_in = '0;
                  rsp_total_in = '0;
                  rsp_err_in   = 1'b1;
               end else if (m_ff == M_W'(1)) begin
                  rsp_cost_in  = '0;
                  rsp_split_in = '0;
                  rsp_total_in = mcod_pkg::TOTAL_W'(m_ff);
                  rsp_err_in   = 1'b0;
               end else begin
                  rsp_cost_in  = tbl_cost_a;
                  rsp_split_in = mcod_pkg::SPLIT_W'(tbl_split);
                  rsp_total_in = mcod_pkg::TOTAL_W'(m_ff);
                  rsp_err_in   = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcod_pkg::ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         m_ff         <= '0;
         err_ff       <= 1'b0;
         diag_ff      <= '0;
         i_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         m_ff         <= m_in;
         err_ff       <= err_in;
         diag_ff      <= diag_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cost_ff  <= rsp_cost_in;
      rsp_split_ff <= rsp_split_in;
      rsp_total_ff <= rsp_total_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.min_cost     = rsp_cost_ff;
   assign rsp_if.top_split    = rsp_split_ff;
   assign rsp_if.matrix_total = rsp_total_ff;
   assign rsp_if.error        = rsp_err_ff;

   `MCOD_ASSERT_IMP(a_done_in_drain, clock, reset, eval_done,
                    state_ff == mcod_pkg::ST_DRAIN,
                    "split evaluation finished outside the drain state")
   `MCOD_ASSERT_ALW(a_cnt_range, clock, reset, cnt_ff <= CNT_W'(SLOTS),
                    "load count beyond the dimension store")
   `MCOD_ASSERT_NXT(a_last_clears, clock, reset, req_fire && req_if.last,
                    (cnt_ff == '0) && !ovf_ff,
                    "load state not cleared after the final dimension")
   `MCOD_ASSERT_IMP(a_write_upper, clock, reset, tbl_cmd.wr,
                    (j > i_ff) && (k_ff == j),
                    "table write outside a finished interval")

endmodule
`default_nettype wire

>>> hw/rtl/matrix_chain_order_dp.sv
// Top level of the matrix chain multiplication order engine.
`timescale 1ns / 1ps
`default_nettype none
// Dimensions p0..pn arrive one per req transaction, at one per cycle while the
// block is loading, and the transaction with last set closes the chain. For a
// chain of m matrices, m of two or more, the block then sweeps the cost and
// split tables diagonal by diagonal and accepts no dimension meanwhile: one
// split is evaluated per cycle by a four-stage pipeline (table reads, partial
// sum and first product, second product, saturating add and compare), and
// every interval also passes through an endpoint fetch and a pipeline drain
// before its cost is written to the table memory. A chain with an error or a
// single matrix skips the sweep. The result waits in an output register, so a
// new chain can start loading while it is still unread. Costs saturate at
// 2^40-1, and on equal cost the later split wins. The tables need no clearing
// after reset, since every longer interval is written before it is read and
// the cost of a single matrix is forced to zero.
module matrix_chain_order_dp #(
   parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF
) (
   input logic        clock,
   input logic        reset,
   mcod_req_if.sink   req_if,
   mcod_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(MAX_MATRICES);
   localparam int DAW = $clog2(MAX_MATRICES + 1);
   localparam int TAW = 2 * IDX_W;

   mcod_pkg::dim_cmd_type       dim_cmd;
   logic [DAW-1:0]              dim_wr_addr;
   logic [DAW-1:0]              dim_rd_a_addr;
   logic [DAW-1:0]              dim_rd_b_addr;
   logic [mcod_pkg::DIM_W-1:0]  dim_a;
   logic [mcod_pkg::DIM_W-1:0]  dim_b;

   mcod_pkg::tbl_cmd_type       tbl_cmd;
   logic [TAW-1:0]              tbl_a_addr;
   logic [TAW-1:0]              tbl_b_addr;
   logic [TAW-1:0]              tbl_wr_addr;
   logic [mcod_pkg::COST_W-1:0] cost_a;
   logic [mcod_pkg::COST_W-1:0] cost_b;
   logic [IDX_W-1:0]            split_a;

   mcod_pkg::ctl_type           ctl;
   logic [IDX_W-1:0]            eval_k;
   logic                        eval_done;
   logic [mcod_pkg::COST_W-1:0] best;
   logic [IDX_W-1:0]            best_k;

   mcod_ctrl #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .dim_cmd       (dim_cmd),
      .dim_wr_addr   (dim_wr_addr),
      .dim_rd_a_addr (dim_rd_a_addr),
      .dim_rd_b_addr (dim_rd_b_addr),
      .tbl_cmd       (tbl_cmd),
      .tbl_a_addr    (tbl_a_addr),
      .tbl_b_addr    (tbl_b_addr),
      .tbl_wr_addr   (tbl_wr_addr),
      .ctl           (ctl),
      .eval_k        (eval_k),
      .eval_done     (eval_done),
      .tbl_cost_a    (cost_a),
      .tbl_split     (split_a)
   );

   mcod_dim_mem #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_dim_mem (
      .clock     (clock),
      .cmd       (dim_cmd),
      .wr_addr   (dim_wr_addr),
      .wr_data   (req_if.dim),
      .rd_a_addr (dim_rd_a_addr),
      .rd_b_addr (dim_rd_b_addr),
      .rd_a_data (dim_a),
      .rd_b_data (dim_b)
   );

   mcod_table_mem #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_table_mem (
      .clock    (clock),
      .cmd      (tbl_cmd),
      .a_addr   (tbl_a_addr),
      .b_addr   (tbl_b_addr),
      .wr_addr  (tbl_wr_addr),
      .wr_cost  (best),
      .wr_split (best_k),
      .cost_a   (cost_a),
      .cost_b   (cost_b),
      .split_a  (split_a)
   );

   mcod_eval #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_eval (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .k      (eval_k),
      .dim_a  (dim_a),
      .dim_b  (dim_b),
      .cost_a (cost_a),
      .cost_b (cost_b),
      .done   (eval_done),
      .best   (best),
      .best_k (best_k)
   );

endmodule
`default_nettype wire

>>> verif/matrix_chain_order_dp_test.sv
// Self-checking testbench for the matrix chain multiplication order engine.
`timescale 1ns / 1ps
module matrix_chain_order_dp_test;

   localparam int MAX_M = mcod_pkg::MAX_MATRICES_DEF;
   localparam int DIM_SLOTS = MAX_M + 1;
   localparam int RANDOM_ITEMS = 950;
   localparam int QUIET_FROM = 800;
   localparam int SETTLE_CYCLES = 1400;

   localparam int DIM_W   = mcod_pkg::DIM_W;
   localparam int COST_W  = mcod_pkg::COST_W;
   localparam int SPLIT_W = mcod_pkg::SPLIT_W;
   localparam int TOTAL_W = mcod_pkg::TOTAL_W;
   localparam logic [COST_W-1:0] COST_SAT = mcod_pkg::COST_SAT;

   typedef struct packed {
      logic [COST_W-1:0]  cost;
      logic [SPLIT_W-1:0] split;
      logic [TOTAL_W-1:0] total;
      logic               err;
   } chain_result_type;

   typedef struct packed {
      logic [DIM_W-1:0] dim;
      logic             lst;
      bit               typed;
      chain_result_type want;
   } dim_row_type;

   typedef enum int {DIMS_WIDE, DIMS_TINY, DIMS_EDGE, DIMS_MAX} dim_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mcod_req_if req ();
   mcod_rsp_if rsp ();

   matrix_chain_order_dp dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed chains. Rows with typed set carry their result; the rest use the predictor.
   dim_row_type directed_rows [0:17] = '{
      '{12'd7,    1'b1, 1'b1, '{40'd0,    4'd0, 5'd0, 1'b1}},   // too few dimensions
      '{12'd4095, 1'b0, 1'b0, '0},
      '{12'd4095, 1'b1, 1'b1, '{40'd0,    4'd0, 5'd1, 1'b0}},   // single matrix
      '{12'd4095, 1'b0, 1'b0, '0},
      '{12'd4095, 1'b0, 1'b0, '0},
      '{12'd4095, 1'b1, 1'b0, '0},
      '{12'd10,   1'b0, 1'b0, '0},
      '{12'd30,   1'b0, 1'b0, '0},
      '{12'd5,    1'b0, 1'b0, '0},
      '{12'd60,   1'b1, 1'b1, '{40'd4500, 4'd1, 5'd3, 1'b0}},
      '{12'd1,    1'b0, 1'b0, '0},
      '{12'd1,    1'b0, 1'b0, '0},
      '{12'd1,    1'b0, 1'b0, '0},
      '{12'd1,    1'b1, 1'b1, '{40'd2,    4'd1, 5'd3, 1'b0}},   // tie goes to the later split
      '{12'd0,    1'b0, 1'b0, '0},
      '{12'd5,    1'b0, 1'b0, '0},
      '{12'd7,    1'b1, 1'b1, '{40'd0,    4'd0, 5'd2, 1'b0}},   // zero dimension
      '{12'd0,    1'b1, 1'b1, '{40'd0,    4'd0, 5'd0, 1'b1}}
   };

   // Predictor state.
   logic [DIM_W-1:0]   dim_mem [0:DIM_SLOTS-1];
   logic [COST_W-1:0]  cost_tab [0:MAX_M-1][0:MAX_M-1];
   logic [SPLIT_W-1:0] split_tab [0:MAX_M-1][0:MAX_M-1];
   int unsigned        dims_held = 0;
   bit                 store_overflow = 1'b0;

   chain_result_type expected_chain_q [$];
   int               mismatch_count = 0;

   // Side information for the transaction currently on the request channel.
   bit               cur_typed = 1'b0;
   chain_result_type cur_want = '0;

   bit          src_idle_on = 1'b0;
   bit          sink_idle_on = 1'b0;
   bit          quiet_phase = 1'b0;
   bit          sink_ready = 1'b0;
   int unsigned sink_stall = 0;
   int unsigned random_items = 0;

   assign rsp.ready = sink_ready;

   function automatic logic [COST_W-1:0] sat_sum(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_W] ? COST_SAT : s[COST_W-1:0];
   endfunction

   // Stores one dimension and, on the closing dimension, solves the whole chain or flags it as an error.
   function automatic bit chain_order_step(input logic [DIM_W-1:0] d, input logic lst,
                                           output chain_result_type r);
      int unsigned m, span, i, j, k;
      logic [COST_W-1:0]  best, cand, prod;
      logic [SPLIT_W-1:0] best_k;
      r = '0;
      if (dims_held < DIM_SLOTS) begin
         dim_mem[dims_held] = d;
         dims_held++;
      end else begin
         store_overflow = 1'b1;
      end
      if (!lst) return 1'b0;
      if (store_overflow || dims_held < 2) begin
         r.err = 1'b1;
         dims_held = 0;
         store_overflow = 1'b0;
         return 1'b1;
      end
      m = dims_held - 1;
      dims_held = 0;
      store_overflow = 1'b0;
      for (i = 0; i < m; i++) begin
         cost_tab[i][i] = '0;
         split_tab[i][i] = '0;
      end
      for (span = 1; span < m; span++) begin
         for (i = 0; i + span < m; i++) begin
            j = i + span;
            best = COST_SAT;
            best_k = SPLIT_W'(i);
            for (k = i; k < j; k++) begin
               // Twelve-bit factors keep the triple product within the cost width.
               prod = COST_W'(dim_mem[i]) * COST_W'(dim_mem[k+1]) * COST_W'(dim_mem[j+1]);
               cand = sat_sum(sat_sum(cost_tab[i][k], cost_tab[k+1][j]), prod);
               if (best >= cand) begin
                  best = cand;
                  best_k = SPLIT_W'(k);
               end
            end
            cost_tab[i][j] = best;
            split_tab[i][j] = best_k;
         end
      end
      r.cost = cost_tab[0][m-1];
      r.split = split_tab[0][m-1];
      r.total = TOTAL_W'(m);
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [COST_W-1:0] want,
                              input logic [COST_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Predicts on accepted dimensions and checks accepted results.
   always @(posedge clock) begin
      chain_result_type res, want;
      if (!reset) begin
         if (req.valid && req.ready) begin
            if (chain_order_step(req.dim, req.last, res))
               expected_chain_q.push_back(cur_typed ? cur_want : res);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_chain_q.size() == 0) begin
               $display({"%0t: unexpected result, expected none, ",
                         "got cost %0d split %0d total %0d error %0b"},
                        $time, rsp.min_cost, rsp.top_split, rsp.matrix_total, rsp.error);
               mismatch_count++;
            end else begin
               want = expected_chain_q.pop_front();
               check_field("min_cost", want.cost, rsp.min_cost);
               check_field("top_split", COST_W'(want.split), COST_W'(rsp.top_split));
               check_field("matrix_total", COST_W'(want.total), COST_W'(rsp.matrix_total));
               check_field("error", COST_W'(want.err), COST_W'(rsp.error));
            end
         end
      end
   end

   // Result channel back-pressure in random bursts.
   always @(negedge clock) begin
      if (quiet_phase || !sink_idle_on) begin
         sink_stall = 0;
         sink_ready = 1'b1;
      end else if (sink_stall != 0) begin
         sink_stall--;
         sink_ready = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         sink_stall = $urandom_range(0, 4);
         sink_ready = 1'b0;
      end else begin
         sink_ready = 1'b1;
      end
   end

   task automatic send_dim(input logic [DIM_W-1:0] d, input logic lst, input bit typed,
                           input chain_result_type want);
      int unsigned gap;
      gap = (src_idle_on && !quiet_phase && $urandom_range(0, 3) == 0)
            ? $urandom_range(1, 5) : 0;
      if (gap != 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid = 1'b1;
      req.dim = d;
      req.last = lst;
      cur_typed = typed;
      cur_want = want;
      do @(posedge clock); while (!req.ready);
   endtask

   function automatic logic [DIM_W-1:0] pick_dim(input dim_mix_type mix);
      case (mix)
         DIMS_TINY: return DIM_W'($urandom_range(1, 3));
         DIMS_EDGE: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return DIM_W'(1);
               2: return '1;
               3: return DIM_W'(1) << $urandom_range(0, DIM_W - 1);
               default: return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
            endcase
         end
         DIMS_MAX: return '1;
         default: return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
      endcase
   endfunction

   task automatic run_chain(input int unsigned len, input dim_mix_type mix);
      int unsigned n;
      src_idle_on = $urandom_range(0, 2) != 0;
      sink_idle_on = $urandom_range(0, 2) != 0;
      for (n = 0; n < len; n++) begin
         send_dim(pick_dim(mix), n == len - 1, 1'b0, '0);
         random_items++;
         quiet_phase = random_items >= QUIET_FROM;
      end
   endtask

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return 1;
      if (r < 10) return $urandom_range(DIM_SLOTS + 1, DIM_SLOTS + 5);
      if (r < 25) return $urandom_range(2, 4);
      if (r < 90) return $urandom_range(5, 12);
      return $urandom_range(13, DIM_SLOTS);
   endfunction

   initial begin
      int unsigned idx;
      dim_mix_type mix;
      req.valid = 1'b0;
      req.dim = '0;
      req.last = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      for (idx = 0; idx < $size(directed_rows); idx++)
         send_dim(directed_rows[idx].dim, directed_rows[idx].lst, directed_rows[idx].typed,
                  directed_rows[idx].want);

      // Longest legal chain at full dimensions, then one dimension too many.
      run_chain(DIM_SLOTS, DIMS_MAX);
      run_chain(DIM_SLOTS + 1, DIMS_WIDE);
      while (random_items < RANDOM_ITEMS) begin
         mix = dim_mix_type'($urandom_range(0, 2));
         run_chain(pick_length(), mix);
      end
      @(negedge clock);
      req.valid = 1'b0;
      cur_typed = 1'b0;

      while (expected_chain_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> matrix_chain_order_dp.f
+incdir+hw/rtl
hw/rtl/mcod_pkg.sv
hw/rtl/mcod_chan_if.sv
hw/rtl/mcod_dim_mem.sv
hw/rtl/mcod_table_mem.sv
hw/rtl/mcod_eval.sv
hw/rtl/mcod_ctrl.sv
hw/rtl/matrix_chain_order_dp.sv
verif/matrix_chain_order_dp_test.sv
